### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the nearest node search unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define NNS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// When ante holds, cons must hold at the following clock edge.
`define NNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define NNS_ASSERT(label, clk, rst_n, prop)
`define NNS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/nns_pkg.sv
`default_nettype none

package nns_pkg;

    localparam int NODES_DEFAULT  = 1024;
    localparam int JOINTS_DEFAULT = 6;
    localparam int MAX_JOINTS     = 6;

    localparam int JOINT_W = 16;
    localparam int STAMP_W = 32;
    localparam int INDEX_W = 10;
    localparam int DIST_W  = 35;
    localparam int SQ_W    = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [JOINT_W-1:0] joint_0;
        logic signed [JOINT_W-1:0] joint_1;
        logic signed [JOINT_W-1:0] joint_2;
        logic signed [JOINT_W-1:0] joint_3;
        logic signed [JOINT_W-1:0] joint_4;
        logic signed [JOINT_W-1:0] joint_5;
        logic [STAMP_W-1:0]        stamp;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] node_index;
        logic [DIST_W-1:0]  distance_sq;
    } response_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic finish;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic query_go;
        logic last_issue;
        logic pipe_empty;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/nns_controller.sv
`default_nettype none

module nns_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire nns_pkg::dp_status_t dp_status,
    output nns_pkg::ctl_cmd_t        ctl_cmd,
    output logic                     busy
);

    nns_pkg::state_t state_reg;
    nns_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nns_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl_cmd    = '0;
        case (state_reg)
            nns_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ctl_cmd.accept = 1'b1;
                    if (dp_status.query_go)
                    begin
                        state_next = nns_pkg::S_SCAN;
                    end
                end
            end
            nns_pkg::S_SCAN:
            begin
                ctl_cmd.scan = 1'b1;
                if (dp_status.last_issue)
                begin
                    state_next = nns_pkg::S_DRAIN;
                end
            end
            nns_pkg::S_DRAIN:
            begin
                // The best node is final once the last distance has left the pipeline.
                if (dp_status.pipe_empty)
                begin
                    ctl_cmd.finish = 1'b1;
                    state_next     = nns_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nns_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != nns_pkg::S_IDLE);

endmodule

`default_nettype wire

### rtl/core/nns_datapath.sv
`default_nettype none

module nns_datapath #(
    parameter int NODES  = nns_pkg::NODES_DEFAULT,
    parameter int JOINTS = nns_pkg::JOINTS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nns_pkg::request_t request,
    input  wire nns_pkg::ctl_cmd_t ctl_cmd,
    output nns_pkg::dp_status_t    dp_status,
    output logic                   done,
    output nns_pkg::response_t     result
);

    localparam int AW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 1);
    localparam int JW    = nns_pkg::JOINT_W;
    localparam int POS_W = JOINTS * JW;

    // Node store: one write port for inserts, one registered read port for the scan.
    logic [POS_W-1:0]            pos_mem [NODES];
    logic [nns_pkg::STAMP_W-1:0] stamp_mem [NODES];

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [POS_W-1:0]            mem_wpos;

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [AW-1:0]               addr_reg;
    logic signed [JW-1:0]        joint_in [nns_pkg::MAX_JOINTS];
    logic signed [JW-1:0]        query_reg [JOINTS];

    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic [AW-1:0]               idx1_reg;
    logic [AW-1:0]               idx2_reg;
    logic [AW-1:0]               idx3_reg;
    logic [POS_W-1:0]            pos1_reg;
    logic [nns_pkg::STAMP_W-1:0] stamp1_reg;
    logic [nns_pkg::STAMP_W-1:0] stamp2_reg;
    logic [nns_pkg::STAMP_W-1:0] stamp3_reg;
    logic signed [JW:0]          diff [JOINTS];
    logic signed [2*JW+1:0]      prod [JOINTS];
    logic [nns_pkg::SQ_W-1:0]    sq2_reg [JOINTS];
    logic [nns_pkg::DIST_W-1:0]  dist_sum;
    logic [nns_pkg::DIST_W-1:0]  dist3_reg;

    logic                        first_reg;
    logic [AW-1:0]               best_idx_reg;
    logic [nns_pkg::DIST_W-1:0]  best_dist_reg;
    logic [nns_pkg::STAMP_W-1:0] best_stamp_reg;
    logic                        better;

    logic                        done_reg;
    logic                        done_next;
    nns_pkg::response_t          result_reg;
    nns_pkg::response_t          result_next;

    assign joint_in[0] = request.joint_0;
    assign joint_in[1] = request.joint_1;
    assign joint_in[2] = request.joint_2;
    assign joint_in[3] = request.joint_3;
    assign joint_in[4] = request.joint_4;
    assign joint_in[5] = request.joint_5;

    assign dp_status.query_go   = (request.op == nns_pkg::OP_QUERY) && (count_reg != '0);
    assign dp_status.last_issue = ((CW'(addr_reg) + CW'(1)) == count_reg);
    assign dp_status.pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    always_comb
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            mem_wpos[j*JW +: JW] = joint_in[j];
        end
    end

    assign mem_waddr = count_reg[AW-1:0];

    // Clear, insert, unused codes and the empty query finish at once; a scan reports on finish.
    always_comb
    begin
        count_next  = count_reg;
        mem_we      = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        if (ctl_cmd.accept && !dp_status.query_go)
        begin
            done_next   = 1'b1;
            result_next = '0;
            case (request.op)
                nns_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                nns_pkg::OP_INSERT:
                begin
                    if (count_reg == CW'(NODES))
                    begin
                        result_next.status = nns_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        mem_we                 = 1'b1;
                        result_next.node_index = nns_pkg::INDEX_W'(count_reg);
                        count_next             = count_reg + CW'(1);
                    end
                end
                nns_pkg::OP_QUERY:
                begin
                    result_next.status = nns_pkg::STATUS_EMPTY;
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
        if (ctl_cmd.finish)
        begin
            done_next               = 1'b1;
            result_next.status      = nns_pkg::STATUS_OK;
            result_next.node_index  = nns_pkg::INDEX_W'(best_idx_reg);
            result_next.distance_sq = best_dist_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[mem_waddr]   <= mem_wpos;
            stamp_mem[mem_waddr] <= request.stamp;
        end
        pos1_reg   <= pos_mem[addr_reg];
        stamp1_reg <= stamp_mem[addr_reg];
    end

    always_comb
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            diff[j] = {pos1_reg[j*JW + JW - 1], pos1_reg[j*JW +: JW]}
                    - {query_reg[j][JW-1], query_reg[j]};
            prod[j] = diff[j] * diff[j];
        end
    end

    always_comb
    begin
        dist_sum = '0;
        for (int j = 0; j < JOINTS; j++)
        begin
            dist_sum = dist_sum + nns_pkg::DIST_W'(sq2_reg[j]);
        end
    end

    // A tie on distance goes to the larger stamp; an equal stamp keeps the earlier node.
    assign better = first_reg || (dist3_reg < best_dist_reg)
                 || ((dist3_reg == best_dist_reg) && (stamp3_reg > best_stamp_reg));

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.accept)
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                query_reg[j] <= joint_in[j];
            end
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        stamp2_reg <= stamp1_reg;
        stamp3_reg <= stamp2_reg;
        for (int j = 0; j < JOINTS; j++)
        begin
            sq2_reg[j] <= prod[j][nns_pkg::SQ_W-1:0];
        end
        dist3_reg <= dist_sum;
        if (v3_reg && better)
        begin
            best_idx_reg   <= idx3_reg;
            best_dist_reg  <= dist3_reg;
            best_stamp_reg <= stamp3_reg;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            addr_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl_cmd.accept)
            begin
                addr_reg <= '0;
            end
            else if (ctl_cmd.scan)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            v1_reg <= ctl_cmd.scan;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (ctl_cmd.accept)
            begin
                first_reg <= 1'b1;
            end
            else if (v3_reg)
            begin
                first_reg <= 1'b0;
            end
            done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/core/nearest_node_search_unit.sv
// Channel   Handshake           Payload
// request   start / busy        request (op, joint_0 .. joint_5, stamp)
// result    done, one cycle     result (status, node_index, distance_sq)
//
// Clear, insert and unused codes return their result in the cycle after the request,
// and the next request may follow at once.
// A query holds busy through its scan and drain: the node store has one read port,
// so the scan reads one node per cycle, then three pipeline stages drain.
// Reset clears the node count and the controller; node contents need no reset.
// The result is shown for one cycle and cannot be held off by the receiver.
`default_nettype none

`include "assert_macros.svh"

module nearest_node_search_unit #(
    parameter int NODES  = nns_pkg::NODES_DEFAULT,
    parameter int JOINTS = nns_pkg::JOINTS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire nns_pkg::request_t request,
    output logic                   done,
    output nns_pkg::response_t     result
);

    nns_pkg::ctl_cmd_t   ctl_cmd;
    nns_pkg::dp_status_t dp_status;

    nns_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .ctl_cmd   (ctl_cmd),
        .busy      (busy)
    );

    nns_datapath #(
        .NODES  (NODES),
        .JOINTS (JOINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .ctl_cmd   (ctl_cmd),
        .dp_status (dp_status),
        .done      (done),
        .result    (result)
    );

    `NNS_ASSERT(a_done_when_idle, clk, rst_n, !done || !busy)
    `NNS_ASSERT_NEXT(a_query_goes_busy, clk, rst_n, start && !busy && dp_status.query_go, busy)
    `NNS_ASSERT(a_finish_after_drain, clk, rst_n, !ctl_cmd.finish || dp_status.pipe_empty)

endmodule

`default_nettype wire

### dv/tb_nearest_node_search_unit.sv
`timescale 1ns / 1ps

module tb_nearest_node_search_unit;

    import nns_pkg::*;

    localparam int NODES        = NODES_DEFAULT;
    localparam int JOINTS       = JOINTS_DEFAULT;
    localparam int RANDOM_ITEMS = 530;

    // The block ignores this op code but still answers with an all-zero result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int {
        FLV_WIDE,
        FLV_NARROW,
        FLV_EDGE,
        FLV_NEAR
    } flavor_t;

    typedef struct {
        request_t  req;
        bit        literal;
        response_t answer;
    } table_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    request_t  request;
    response_t result;

    // Shadow copy of the node store.
    logic signed [JOINT_W-1:0] store_joint [NODES][MAX_JOINTS];
    logic [STAMP_W-1:0]        store_stamp [NODES];
    int                        store_count;

    response_t  answers_due [$];
    table_row_t directed_rows [$];

    int     mismatches;
    int     results_seen;
    int     quiet_left;
    int     sent_total;
    int     n_insert;
    int     n_query;
    int     n_clear;
    int     n_unused;
    int     n_full;
    int     n_empty;
    longint cycles;
    longint cycle_budget;

    nearest_node_search_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin : watchdog
        while (cycles <= 4 * cycle_budget + 5000)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(string name, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Applies one request to the shadow store and returns the answer it must produce.
    function automatic response_t answer_request(request_t r);
        response_t                 a;
        logic signed [JOINT_W-1:0] q [MAX_JOINTS];
        longint                    diff;
        longint                    d;
        longint                    best_d;
        int                        best;
        int                        i;
        int                        j;
        q[0] = r.joint_0;
        q[1] = r.joint_1;
        q[2] = r.joint_2;
        q[3] = r.joint_3;
        q[4] = r.joint_4;
        q[5] = r.joint_5;
        a = '0;
        best = 0;
        best_d = 0;
        case (r.op)
            OP_CLEAR:
                store_count = 0;
            OP_INSERT:
                if (store_count >= NODES)
                    a.status = STATUS_FULL;
                else
                begin
                    for (j = 0; j < MAX_JOINTS; j++)
                        store_joint[store_count][j] = q[j];
                    store_stamp[store_count] = r.stamp;
                    a.node_index = INDEX_W'(store_count);
                    store_count++;
                end
            OP_QUERY:
                if (store_count == 0)
                    a.status = STATUS_EMPTY;
                else
                begin
                    for (i = 0; i < store_count; i++)
                    begin
                        d = 0;
                        for (j = 0; j < JOINTS; j++)
                        begin
                            diff = longint'(store_joint[i][j]) - longint'(q[j]);
                            d += diff * diff;
                        end
                        // Equal distance goes to the later stamp; equal stamps keep
                        // the node that was inserted first.
                        if (i == 0 || d < best_d ||
                            (d == best_d && store_stamp[i] > store_stamp[best]))
                        begin
                            best = i;
                            best_d = d;
                        end
                    end
                    a.node_index = INDEX_W'(best);
                    a.distance_sq = DIST_W'(best_d);
                end
            default:
                ;
        endcase
        return a;
    endfunction

    function automatic request_t make_req(logic [1:0] op, int j0, int j1, int j2, int j3,
                                          int j4, int j5, logic [STAMP_W-1:0] stamp);
        request_t r;
        r.op = op;
        r.joint_0 = JOINT_W'(j0);
        r.joint_1 = JOINT_W'(j1);
        r.joint_2 = JOINT_W'(j2);
        r.joint_3 = JOINT_W'(j3);
        r.joint_4 = JOINT_W'(j4);
        r.joint_5 = JOINT_W'(j5);
        r.stamp = stamp;
        return r;
    endfunction

    function automatic request_t random_request(logic [1:0] op, flavor_t flavor);
        request_t                  r;
        logic signed [JOINT_W-1:0] jv [MAX_JOINTS];
        int                        src;
        int                        v;
        int                        k;
        src = (store_count > 0) ? int'($urandom_range(0, store_count - 1)) : 0;
        for (k = 0; k < MAX_JOINTS; k++)
        begin
            case (flavor)
                FLV_WIDE:
                    v = int'($urandom);
                FLV_NARROW:
                    v = int'($urandom_range(0, 6)) - 3;
                FLV_EDGE:
                    case ($urandom_range(0, 5))
                        0: v = -32768;
                        1: v = -32767;
                        2: v = -1;
                        3: v = 0;
                        4: v = 1;
                        default: v = 32767;
                    endcase
                default:
                    if (store_count == 0)
                        v = int'($urandom_range(0, 6)) - 3;
                    else
                    begin
                        // Copies of stored nodes, sometimes nudged, give exact ties.
                        v = store_joint[src][k];
                        if ($urandom_range(0, 3) == 0)
                            v += int'($urandom_range(0, 4)) - 2;
                    end
            endcase
            jv[k] = JOINT_W'(v);
        end
        r.op = op;
        r.joint_0 = jv[0];
        r.joint_1 = jv[1];
        r.joint_2 = jv[2];
        r.joint_3 = jv[3];
        r.joint_4 = jv[4];
        r.joint_5 = jv[5];
        case ($urandom_range(0, 2))
            0: r.stamp = $urandom;
            1: r.stamp = $urandom_range(0, 3);
            default: r.stamp = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

    task automatic add_row(request_t req, bit literal, logic [1:0] st, int idx,
                           logic [DIST_W-1:0] dist_val);
        table_row_t row;
        row.req = req;
        row.literal = literal;
        row.answer.status = st;
        row.answer.node_index = INDEX_W'(idx);
        row.answer.distance_sq = dist_val;
        directed_rows = {directed_rows, row};
    endtask

    // Issues one request and records its answer once the block has taken it.
    task automatic send_request(request_t r, bit literal, response_t typed);
        int        gap;
        response_t predicted;
        if (quiet_left > 0)
        begin
            gap = 0;
            quiet_left--;
        end
        else
        begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 29) == 0)
                quiet_left = $urandom_range(10, 40);
        end
        cycle_budget += gap + store_count + 10;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = answer_request(r);
        answers_due = {answers_due, (literal ? typed : predicted)};
        case (r.op)
            OP_CLEAR:  n_clear++;
            OP_INSERT: n_insert++;
            OP_QUERY:  n_query++;
            default:   n_unused++;
        endcase
        sent_total++;
        if (predicted.status == STATUS_FULL)
            n_full++;
        if (predicted.status == STATUS_EMPTY)
            n_empty++;
    endtask

    always @(posedge clk)
    begin : result_check
        response_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (answers_due.size() == 0)
                report_mismatch($sformatf("result with no request outstanding, status %0d",
                                          result.status));
            else
            begin
                want = answers_due.pop_front();
                check_field("status", DIST_W'(result.status), DIST_W'(want.status));
                check_field("node_index", DIST_W'(result.node_index),
                            DIST_W'(want.node_index));
                check_field("distance_sq", result.distance_sq, want.distance_sq);
            end
        end
    end

    initial
    begin : stimulus
        int      k;
        int      n_ins;
        int      n_q;
        int      pick;
        int      random_base;
        flavor_t flavor;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        cycles = 0;
        cycle_budget = 200;
        store_count = 0;
        mismatches = 0;
        results_seen = 0;
        quiet_left = 0;
        sent_total = 0;
        n_insert = 0;
        n_query = 0;
        n_clear = 0;
        n_unused = 0;
        n_full = 0;
        n_empty = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, the empty and ignored cases, and the tie rules.
        add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_EMPTY, 0, 0);
        add_row(make_req(OP_UNUSED, -1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF), 1, STATUS_OK, 0, 0);
        add_row(make_req(OP_INSERT, 32767, 32767, 32767, 32767, 32767, 32767, 0),
                1, STATUS_OK, 0, 0);
        add_row(make_req(OP_QUERY, -32768, -32768, -32768, -32768, -32768, -32768,
                         32'hFFFF_FFFF), 1, STATUS_OK, 0, 35'd25769017350);
        add_row(make_req(OP_INSERT, -32768, -32768, -32768, -32768, -32768, -32768,
                         32'hFFFF_FFFF), 1, STATUS_OK, 1, 0);
        add_row(make_req(OP_QUERY, 32767, 32767, 32767, 32767, 32767, 32767, 0),
                1, STATUS_OK, 0, 0);
        add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_OK, 0, 35'd6442057734);
        add_row(make_req(OP_UNUSED, 5, 5, 5, 5, 5, 5, 5), 1, STATUS_OK, 0, 0);
        add_row(make_req(OP_QUERY, -32768, -32768, -32768, -32768, -32768, -32768, 0),
                1, STATUS_OK, 1, 0);
        add_row(make_req(OP_CLEAR, 123, -456, 789, -1011, 1213, -1415, 77), 1, STATUS_OK, 0, 0);
        add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_EMPTY, 0, 0);
        add_row(make_req(OP_INSERT, 3, 0, 0, 0, 0, 0, 7), 1, STATUS_OK, 0, 0);
        add_row(make_req(OP_INSERT, -1, 0, 0, 0, 0, 0, 9), 1, STATUS_OK, 1, 0);
        add_row(make_req(OP_QUERY, 1, 0, 0, 0, 0, 0, 0), 1, STATUS_OK, 1, 4);
        add_row(make_req(OP_INSERT, 1, 2, 0, 0, 0, 0, 9), 1, STATUS_OK, 2, 0);
        add_row(make_req(OP_QUERY, 1, 0, 0, 0, 0, 0, 0), 1, STATUS_OK, 1, 4);
        add_row(make_req(OP_INSERT, 1, 0, 0, 0, 0, -2, 10), 1, STATUS_OK, 3, 0);
        add_row(make_req(OP_QUERY, 1, 0, 0, 0, 0, 0, 0), 1, STATUS_OK, 3, 4);
        add_row(make_req(OP_INSERT, 1, 0, 0, 0, 0, 1, 0), 1, STATUS_OK, 4, 0);
        add_row(make_req(OP_QUERY, 1, 0, 0, 0, 0, 0, 0), 1, STATUS_OK, 4, 1);
        add_row(make_req(OP_INSERT, -12345, 2047, 4096, -4096, 31000, -31000, 32'h8000_0001),
                0, STATUS_OK, 0, 0);
        add_row(make_req(OP_QUERY, 100, -200, 300, -400, 500, -600, 0), 0, STATUS_OK, 0, 0);
        add_row(make_req(OP_QUERY, -12000, 2000, 4000, -4000, 30000, -30000, 3),
                0, STATUS_OK, 0, 0);

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].literal,
                         directed_rows[k].answer);

        // Edge positions, a stray code and a query right after a clear.
        send_request(random_request(OP_CLEAR, FLV_WIDE), 1'b0, '0);
        for (k = 0; k < 3; k++)
        begin
            send_request(random_request(OP_INSERT, FLV_EDGE), 1'b0, '0);
            send_request(random_request(OP_QUERY, (k == 0) ? FLV_WIDE : FLV_NEAR), 1'b0, '0);
        end
        send_request(random_request(OP_UNUSED, FLV_WIDE), 1'b0, '0);
        send_request(random_request(OP_CLEAR, FLV_WIDE), 1'b0, '0);
        send_request(random_request(OP_QUERY, FLV_WIDE), 1'b0, '0);

        // Mostly clear-insert-query runs with random content, plus stray requests.
        random_base = sent_total;
        while (sent_total - random_base < RANDOM_ITEMS)
        begin
            if (store_count > 700 || $urandom_range(0, 4) != 0)
                send_request(random_request(OP_CLEAR, FLV_WIDE), 1'b0, '0);
            flavor = flavor_t'($urandom_range(0, 3));
            n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
            for (k = 0; k < n_ins; k++)
            begin
                pick = $urandom_range(0, 39);
                if (pick == 0)
                    send_request(random_request(OP_CLEAR, flavor), 1'b0, '0);
                else if (pick < 3)
                    send_request(random_request(OP_UNUSED, FLV_WIDE), 1'b0, '0);
                else if (pick < 7)
                    send_request(random_request(OP_QUERY, flavor), 1'b0, '0);
                else
                    send_request(random_request(OP_INSERT, ($urandom_range(0, 3) == 0) ?
                                 flavor_t'($urandom_range(0, 3)) : flavor), 1'b0, '0);
            end
            n_q = $urandom_range(1, 6);
            for (k = 0; k < n_q; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_request(random_request(OP_UNUSED, FLV_WIDE), 1'b0, '0);
                send_request(random_request(OP_QUERY, ($urandom_range(0, 1) == 0) ?
                             FLV_NEAR : flavor), 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d inserts, %0d queries, %0d clears and %0d unused codes; %0d results",
                 n_insert, n_query, n_clear, n_unused, results_seen);
        $display("%0d requests in all, %0d rejected inserts, %0d empty-store queries",
                 sent_total, n_full, n_empty);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### nearest_node_search_unit.f
+incdir+rtl/core
rtl/core/nns_pkg.sv
rtl/core/nns_controller.sv
rtl/core/nns_datapath.sv
rtl/core/nearest_node_search_unit.sv
dv/tb_nearest_node_search_unit.sv
